// ----- hdl/epm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package epm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP        = 3'd4;

  localparam logic [10:0] IMAGE_HEIGHT_RST   = 11'd480;
  localparam logic [5:0]  SAMPLE_OFFSET_RST  = 6'd10;
  localparam logic [7:0]  EDGE_THRESHOLD_RST = 8'd8;
  localparam logic [9:0]  MAX_GAP_RST        = 10'd45;
  localparam logic [9:0]  MIN_GAP_RST        = 10'd15;

  // Candidates emitted per input item at most
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [10:0] image_height;
    logic [5:0]  sample_offset;
    logic [7:0]  edge_threshold;
    logic [9:0]  max_gap;
    logic [9:0]  min_gap;
  } cfg_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
  } point_t;

  typedef struct packed {
    logic   start;
    logic   clear;
    point_t peak;
  } scan_req_t;

  typedef struct packed {
    point_t rising;
    point_t falling;
    point_t center;
    logic   last;
  } cand_t;

endpackage

`default_nettype wire

// ----- hdl/epm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module epm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/epm_track.sv -----
`timescale 1ns / 1ps
`default_nettype none

module epm_track import epm_pkg::*; #(
  parameter int RISING_DEPTH = 16,
  localparam int AW = (RISING_DEPTH > 1) ? $clog2(RISING_DEPTH) : 1,
  localparam int CW = $clog2(RISING_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          accept,
  input  wire logic          frame_start,
  input  wire logic [9:0]    point_x,
  input  wire logic [9:0]    point_y,
  input  wire logic [7:0]    luma,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output point_t             wr_data,
  output logic [CW-1:0]      rising_count,
  output scan_req_t          req
);

  logic [7:0]         previous_luma;
  logic signed [9:0]  gradient_low;
  logic signed [9:0]  gradient_high;
  point_t             peak_point;

  logic signed [9:0]  thr;
  logic signed [9:0]  neg_thr;
  logic signed [9:0]  g;
  logic [10:0]        row_sum;
  logic [10:0]        row_clamp;
  point_t             pt;
  logic               lt;
  logic               gt;
  logic signed [9:0]  low1;
  logic signed [9:0]  high1;
  point_t             peak1;
  logic               rising_full;
  logic               push;

  always_comb begin
    thr     = signed'({2'b00, cfg.edge_threshold});
    neg_thr = -thr;
    g       = signed'({2'b00, luma}) - signed'({2'b00, previous_luma});

    // Sample row, clamped to the image and to the coordinate range
    row_sum = {1'b0, point_y} + {5'b0, cfg.sample_offset};
    if (row_sum >= cfg.image_height) begin
      row_clamp = (cfg.image_height == 11'd0) ? 11'd0 : cfg.image_height - 11'd1;
    end else begin
      row_clamp = row_sum;
    end
    pt.x = point_x;
    pt.y = (row_clamp > 11'd1023) ? 10'd1023 : row_clamp[9:0];

    rising_full = (rising_count == CW'(RISING_DEPTH));
    lt    = (g < gradient_low);
    push  = lt && (gradient_high > thr) && !rising_full;
    low1  = lt ? g : gradient_low;
    high1 = lt ? neg_thr : gradient_high;
    peak1 = lt ? pt : peak_point;
    gt    = (g > high1);
  end

  assign wr_en   = accept && !frame_start && push;
  assign wr_addr = rising_count[AW-1:0];
  assign wr_data = peak_point;

  assign req.start = accept && !frame_start && gt && (low1 < neg_thr);
  assign req.clear = accept && frame_start;
  assign req.peak  = peak1;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_luma <= '0;
      gradient_low  <= signed'({2'b00, EDGE_THRESHOLD_RST});
      gradient_high <= -signed'({2'b00, EDGE_THRESHOLD_RST});
      peak_point    <= '0;
      rising_count  <= '0;
    end else if (accept) begin
      previous_luma <= luma;
      if (frame_start) begin
        gradient_low  <= thr;
        gradient_high <= neg_thr;
        peak_point    <= '0;
        rising_count  <= '0;
      end else begin
        if (gt) begin
          gradient_high <= g;
          gradient_low  <= thr;
          peak_point    <= pt;
        end else if (lt) begin
          gradient_low  <= g;
          gradient_high <= neg_thr;
          peak_point    <= pt;
        end
        if (push) begin
          rising_count <= rising_count + CW'(1);
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rising_count <= CW'(RISING_DEPTH))
    else $error("rising edge count beyond list depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> rising_count == $past(rising_count) + CW'(1))
    else $error("rising edge written without count advance");

  a_no_push_and_scan: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && req.start))
    else $error("rising edge stored on an item that starts a scan");

endmodule

`default_nettype wire

// ----- hdl/epm_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module epm_scan import epm_pkg::*; #(
  parameter int RISING_DEPTH = 16,
  parameter int POST_DEPTH = 16,
  localparam int AW  = (RISING_DEPTH > 1) ? $clog2(RISING_DEPTH) : 1,
  localparam int CW  = $clog2(RISING_DEPTH + 1),
  localparam int PCW = $clog2(POST_DEPTH + 1),
  localparam int NW  = $clog2(MAX_RESULTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire scan_req_t     req,
  input  wire logic [CW-1:0] rising_count,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire point_t        rd_data,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cand_t              out_cand
);

  point_t          peak;
  logic [CW-1:0]   idx;
  logic            ev_valid;
  logic [PCW-1:0]  post_count;
  logic [9:0]      post_max;
  logic [NW-1:0]   n;
  logic            pend_valid;
  cand_t           pend;

  logic signed [10:0] d;
  logic [10:0]     sum_x;
  logic [10:0]     sum_y;
  cand_t           new_cand;
  cand_t           flush_cand;
  logic            too_far;
  logic            too_near;
  logic            has_post;
  logic            post_full;
  logic            n_full;
  logic            emit;
  logic            stop;
  logic            more;
  logic            out_free;
  logic            finishing;
  logic            need_push;
  logic            advance;
  logic            push_out;

  always_comb begin
    d         = signed'({1'b0, peak.x}) - signed'({1'b0, rd_data.x});
    too_far   = d > signed'({1'b0, cfg.max_gap});
    too_near  = d < signed'({1'b0, cfg.min_gap});
    // Any stored post at or right of this edge is covered by the running max
    has_post  = (post_count != '0) && (post_max >= rd_data.x);
    post_full = (post_count == PCW'(POST_DEPTH));
    n_full    = (n == NW'(MAX_RESULTS));

    emit = 1'b0;
    stop = 1'b0;
    if (too_far || (!too_near && (has_post || post_full))) begin
      emit = 1'b0;
    end else if (too_near || n_full) begin
      stop = 1'b1;
    end else begin
      emit = 1'b1;
    end

    sum_x = {1'b0, rd_data.x} + {1'b0, peak.x};
    sum_y = {1'b0, rd_data.y} + {1'b0, peak.y};
    new_cand.rising   = rd_data;
    new_cand.falling  = peak;
    new_cand.center.x = sum_x[10:1];
    new_cand.center.y = sum_y[10:1];
    new_cand.last     = 1'b0;

    more      = (idx < rising_count);
    out_free  = !out_valid || out_ready;
    finishing = busy && ((ev_valid && stop) || (!ev_valid && !more));
    need_push = pend_valid && (finishing || (ev_valid && emit));
    advance   = busy && !(need_push && !out_free);
    push_out  = advance && need_push;

    // The held candidate is last of the run when the scan ends
    flush_cand      = pend;
    flush_cand.last = finishing;
  end

  assign rd_en   = advance && !finishing && more;
  assign rd_addr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      ev_valid   <= 1'b0;
      post_count <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push_out) begin
        out_valid <= 1'b1;
        out_cand  <= flush_cand;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (req.clear) begin
        post_count <= '0;
      end
      if (req.start) begin
        busy     <= 1'b1;
        idx      <= '0;
        ev_valid <= 1'b0;
        n        <= '0;
        peak     <= req.peak;
      end else if (advance) begin
        if (finishing) begin
          busy       <= 1'b0;
          ev_valid   <= 1'b0;
          pend_valid <= 1'b0;
        end else begin
          if (ev_valid && emit) begin
            pend       <= new_cand;
            pend_valid <= 1'b1;
            post_count <= post_count + PCW'(1);
            if (post_count == '0 || new_cand.center.x > post_max) begin
              post_max <= new_cand.center.x;
            end
            n <= n + NW'(1);
          end
          ev_valid <= more;
          if (more) begin
            idx <= idx + CW'(1);
          end
        end
      end
    end
  end

  a_post_bound: assert property (@(posedge clk) disable iff (rst)
    post_count <= PCW'(POST_DEPTH))
    else $error("post count beyond list depth");

  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend_valid && !ev_valid)
    else $error("held candidate or read left over after scan end");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> busy && (idx < rising_count))
    else $error("rising edge read outside the stored list");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(MAX_RESULTS))
    else $error("too many candidates for one item");

endmodule

`default_nettype wire

// ----- hdl/edge_pair_post_matcher.sv -----
// Edge pair post matcher.
// Input channel (in_valid/in_ready): one border point per transfer with its
// luma sample. A frame_start transfer clears the rising edge and post lists.
// Output channel (out_valid/out_ready): one post candidate per transfer;
// last_of_run marks the final candidate caused by one input item.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; write only while the block is idle.
// Timing: an item that ends a falling edge scans the rising edge memory
// through its single read port, one entry per cycle unless the output
// stalls, and in_ready stays low until the scan ends (at the list end, or
// early when a gap is too short or the result limit is reached). Each
// candidate waits in a hold register until the next match or the scan end;
// the last one appears at the edge where in_ready returns high.
// Reset: configuration returns to its defaults, both lists are empty and
// the gradient extremes take the default threshold. No clearing pass.
// Stall: a held output register and one pending candidate; when both are
// full the scan holds until out_ready drains the output.
`timescale 1ns / 1ps
`default_nettype none

module edge_pair_post_matcher import epm_pkg::*; #(
  parameter int RISING_DEPTH = 16,
  parameter int POST_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  frame_start,
  input  wire logic [9:0]            point_x,
  input  wire logic [9:0]            point_y,
  input  wire logic [7:0]            luma,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [9:0]                 rising_x,
  output logic [9:0]                 rising_y,
  output logic [9:0]                 falling_x,
  output logic [9:0]                 falling_y,
  output logic [9:0]                 center_x,
  output logic [9:0]                 center_y,
  output logic                       last_of_run
);

  localparam int AW = (RISING_DEPTH > 1) ? $clog2(RISING_DEPTH) : 1;
  localparam int CW = $clog2(RISING_DEPTH + 1);

  cfg_t            cfg;
  logic            busy;
  logic            accept;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  point_t          wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  point_t          rd_data;
  logic [CW-1:0]   rising_count;
  scan_req_t       req;
  cand_t           out_cand;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_height   <= IMAGE_HEIGHT_RST;
      cfg.sample_offset  <= SAMPLE_OFFSET_RST;
      cfg.edge_threshold <= EDGE_THRESHOLD_RST;
      cfg.max_gap        <= MAX_GAP_RST;
      cfg.min_gap        <= MIN_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data;
        REG_SAMPLE_OFFSET:  cfg.sample_offset  <= cfg_data[5:0];
        REG_EDGE_THRESHOLD: cfg.edge_threshold <= cfg_data[7:0];
        REG_MAX_GAP:        cfg.max_gap        <= cfg_data[9:0];
        REG_MIN_GAP:        cfg.min_gap        <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  epm_track #(
    .RISING_DEPTH(RISING_DEPTH)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .frame_start  (frame_start),
    .point_x      (point_x),
    .point_y      (point_y),
    .luma         (luma),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rising_count (rising_count),
    .req          (req)
  );

  // Writes happen only on accepted items and reads only during a scan,
  // so the two never touch the same entry in one cycle.
  epm_ram #(
    .WIDTH($bits(point_t)),
    .DEPTH(RISING_DEPTH)
  ) u_rising_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  epm_scan #(
    .RISING_DEPTH(RISING_DEPTH),
    .POST_DEPTH(POST_DEPTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req          (req),
    .rising_count (rising_count),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cand     (out_cand)
  );

  assign rising_x    = out_cand.rising.x;
  assign rising_y    = out_cand.rising.y;
  assign falling_x   = out_cand.falling.x;
  assign falling_y   = out_cand.falling.y;
  assign center_x    = out_cand.center.x;
  assign center_y    = out_cand.center.y;
  assign last_of_run = out_cand.last;

endmodule

`default_nettype wire

// ----- bench/post_candidate_checker.sv -----
`timescale 1ns / 1ps

module post_candidate_checker import epm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  frame_start,
  input  logic [9:0]            point_x,
  input  logic [9:0]            point_y,
  input  logic [7:0]            luma,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [9:0]            rising_x,
  input  logic [9:0]            rising_y,
  input  logic [9:0]            falling_x,
  input  logic [9:0]            falling_y,
  input  logic [9:0]            center_x,
  input  logic [9:0]            center_y,
  input  logic                  last_of_run,
  output int                    mismatches,
  output int                    pending
);

  localparam int RISE_SLOTS = 16;
  localparam int POST_SLOTS = 16;

  cfg_t              regs;
  logic [7:0]        prev_luma;
  logic signed [9:0] grad_low;
  logic signed [9:0] grad_high;
  point_t            peak;
  point_t            rise_mem [RISE_SLOTS];
  int                rise_cnt;
  logic [9:0]        post_cols [POST_SLOTS];
  int                post_cnt;
  cand_t             expected_posts [$];
  int                err_cnt = 0;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic clear_frame();
    grad_low  = 10'(int'(regs.edge_threshold));
    grad_high = 10'(-int'(regs.edge_threshold));
    peak      = '0;
    rise_cnt  = 0;
    post_cnt  = 0;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_HEIGHT:   regs.image_height   = data;
      REG_SAMPLE_OFFSET:  regs.sample_offset  = data[5:0];
      REG_EDGE_THRESHOLD: regs.edge_threshold = data[7:0];
      REG_MAX_GAP:        regs.max_gap        = data[9:0];
      REG_MIN_GAP:        regs.min_gap        = data[9:0];
      default: ;
    endcase
  endtask

  // Track the gradient extremes and queue the candidates this point produces.
  task automatic match_edges(logic fs, logic [9:0] px, logic [9:0] py, logic [7:0] lum);
    int          row;
    int          grad;
    int          thr;
    int          gap;
    bit          blocked;
    point_t      here;
    cand_t       cand;
    cand_t       found_q [$];
    logic [10:0] sum_x;
    logic [10:0] sum_y;
    if (fs) begin
      clear_frame();
      prev_luma = lum;
      return;
    end
    row = int'(py) + int'(regs.sample_offset);
    if (row >= int'(regs.image_height))
      row = (regs.image_height == 0) ? 0 : int'(regs.image_height) - 1;
    if (row > 1023)
      row = 1023;
    here.x = px;
    here.y = row[9:0];
    grad = int'(lum) - int'(prev_luma);
    thr  = int'(regs.edge_threshold);

    if (grad < grad_low) begin
      if (grad_high > thr && rise_cnt < RISE_SLOTS) begin
        rise_mem[rise_cnt] = peak;
        rise_cnt++;
      end
      grad_low  = 10'(grad);
      grad_high = 10'(-thr);
      peak      = here;
    end

    if (grad > grad_high) begin
      if (grad_low < -thr) begin
        for (int i = 0; i < rise_cnt; i++) begin
          gap = int'(peak.x) - int'(rise_mem[i].x);
          if (gap > int'(regs.max_gap))
            continue;
          if (gap < int'(regs.min_gap))
            break;
          // a post already at or right of this rising edge claims it
          blocked = 1'b0;
          for (int j = 0; j < post_cnt; j++)
            if (post_cols[j] >= rise_mem[i].x)
              blocked = 1'b1;
          if (blocked || post_cnt >= POST_SLOTS)
            continue;
          if (found_q.size() >= MAX_RESULTS)
            break;
          sum_x = {1'b0, rise_mem[i].x} + {1'b0, peak.x};
          sum_y = {1'b0, rise_mem[i].y} + {1'b0, peak.y};
          cand.rising   = rise_mem[i];
          cand.falling  = peak;
          cand.center.x = sum_x[10:1];
          cand.center.y = sum_y[10:1];
          cand.last     = 1'b0;
          post_cols[post_cnt] = sum_x[10:1];
          post_cnt++;
          found_q.insert(found_q.size(), cand);
        end
      end
      grad_high = 10'(grad);
      grad_low  = 10'(thr);
      peak      = here;
    end

    prev_luma = lum;
    if (found_q.size() > 0) begin
      cand = found_q.pop_back();
      cand.last = 1'b1;
      found_q.insert(found_q.size(), cand);
    end
    while (found_q.size() > 0)
      expected_posts.insert(expected_posts.size(), found_q.pop_front());
  endtask

  task automatic check_field(string name, logic [9:0] got, logic [9:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic check_candidate();
    cand_t want;
    if (expected_posts.size() == 0) begin
      report_mismatch($sformatf("candidate (%0d,%0d)-(%0d,%0d) with nothing pending",
                                rising_x, rising_y, falling_x, falling_y));
      return;
    end
    want = expected_posts.pop_front();
    check_field("rising_x", rising_x, want.rising.x);
    check_field("rising_y", rising_y, want.rising.y);
    check_field("falling_x", falling_x, want.falling.x);
    check_field("falling_y", falling_y, want.falling.y);
    check_field("center_x", center_x, want.center.x);
    check_field("center_y", center_y, want.center.y);
    check_field("last_of_run", {9'd0, last_of_run}, {9'd0, want.last});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.image_height   = IMAGE_HEIGHT_RST;
      regs.sample_offset  = SAMPLE_OFFSET_RST;
      regs.edge_threshold = EDGE_THRESHOLD_RST;
      regs.max_gap        = MAX_GAP_RST;
      regs.min_gap        = MIN_GAP_RST;
      prev_luma           = '0;
      clear_frame();
      expected_posts.delete();
    end else begin
      if (out_valid && out_ready)
        check_candidate();
      if (in_valid && in_ready)
        match_edges(frame_start, point_x, point_y, luma);
      // a register write takes effect after this edge
      if (cfg_valid && cfg_ready)
        write_register(cfg_index, cfg_data);
    end
    pending    <= expected_posts.size();
    mismatches <= err_cnt;
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import epm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  frame_start = 1'b0;
  logic [9:0]            point_x = '0;
  logic [9:0]            point_y = '0;
  logic [7:0]            luma = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [9:0]            rising_x;
  logic [9:0]            rising_y;
  logic [9:0]            falling_x;
  logic [9:0]            falling_y;
  logic [9:0]            center_x;
  logic [9:0]            center_y;
  logic                  last_of_run;

  int mismatches;
  int pending;
  int send_idle = 37;
  int recv_idle = 66;
  int sent_cnt = 0;
  bit hold_req = 1'b0;

  always #4 clk = ~clk;

  edge_pair_post_matcher dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .frame_start(frame_start),
    .point_x(point_x), .point_y(point_y), .luma(luma),
    .out_valid(out_valid), .out_ready(out_ready),
    .rising_x(rising_x), .rising_y(rising_y), .falling_x(falling_x), .falling_y(falling_y),
    .center_x(center_x), .center_y(center_y), .last_of_run(last_of_run)
  );

  post_candidate_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .frame_start(frame_start),
    .point_x(point_x), .point_y(point_y), .luma(luma),
    .out_valid(out_valid), .out_ready(out_ready),
    .rising_x(rising_x), .rising_y(rising_y), .falling_x(falling_x), .falling_y(falling_y),
    .center_x(center_x), .center_y(center_y), .last_of_run(last_of_run),
    .mismatches(mismatches), .pending(pending)
  );

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_point(bit fs, logic [9:0] x, logic [9:0] y, logic [7:0] lum);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid    <= 1'b1;
    frame_start <= fs;
    point_x     <= x;
    point_y     <= y;
    luma        <= lum;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
  endtask

  task automatic send_noise();
    send_point($urandom_range(0, 7) == 0, 10'($urandom), 10'($urandom), 8'($urandom));
  endtask

  // One border run with luma steps, small jitter and some stray points.
  task automatic send_frame();
    logic [9:0] x;
    logic [9:0] row;
    int         level;
    int         r;
    x     = 10'($urandom_range(0, 900));
    row   = 10'($urandom);
    level = $urandom_range(0, 255);
    send_point(1'b1, x, row, 8'(level));
    repeat ($urandom_range(8, 40)) begin
      x = x + 10'($urandom_range(1, 6));
      r = $urandom_range(0, 99);
      if (r < 15)
        level = level + int'($urandom_range(20, 150));
      else if (r < 30)
        level = level - int'($urandom_range(20, 150));
      else
        level = level + int'($urandom_range(0, 6)) - 3;
      if (level > 255)
        level = 255;
      if (level < 0)
        level = 0;
      if (r >= 94)
        send_noise();
      else
        send_point(1'b0, x, row + 10'($urandom_range(0, 3)), 8'(level));
    end
  endtask

  // Many bright bars in one frame: fills the rising edge list.
  task automatic send_bump_train();
    logic [9:0] x;
    logic [9:0] row;
    logic [7:0] bright;
    x   = 10'($urandom_range(0, 100));
    row = 10'($urandom);
    send_point(1'b1, x, row, 8'd10);
    repeat ($urandom_range(17, 20)) begin
      bright = 8'($urandom_range(180, 255));
      repeat ($urandom_range(2, 6)) begin
        x = x + 10'($urandom_range(3, 6));
        send_point(1'b0, x, row, bright);
      end
      repeat ($urandom_range(2, 3)) begin
        x = x + 10'($urandom_range(3, 6));
        send_point(1'b0, x, row, 8'($urandom_range(0, 30)));
      end
    end
  endtask

  task automatic send_traffic(int quota);
    int first;
    first = sent_cnt;
    while (sent_cnt - first < quota) begin
      if ($urandom_range(0, 99) < 5)
        send_bump_train();
      else
        send_frame();
    end
  endtask

  task automatic send_directed();
    send_point(1'b1, 10'd0, 10'd0, 8'd0);
    send_point(1'b0, 10'd0, 10'd1023, 8'd0);      // sample row clamps
    send_point(1'b0, 10'd10, 10'd100, 8'd200);
    send_point(1'b0, 10'd14, 10'd100, 8'd200);
    send_point(1'b0, 10'd40, 10'd200, 8'd0);
    send_point(1'b0, 10'd44, 10'd200, 8'd0);      // single pair
    send_point(1'b1, 10'd90, 10'd300, 8'd0);
    send_point(1'b0, 10'd100, 10'd300, 8'd100);
    send_point(1'b0, 10'd102, 10'd300, 8'd100);
    send_point(1'b0, 10'd120, 10'd301, 8'd200);
    send_point(1'b0, 10'd122, 10'd301, 8'd200);
    send_point(1'b0, 10'd145, 10'd302, 8'd0);
    send_point(1'b0, 10'd147, 10'd302, 8'd0);     // far edge pairs, near one has a post
    send_point(1'b0, 10'd160, 10'd303, 8'd150);
    send_point(1'b0, 10'd162, 10'd303, 8'd150);
    send_point(1'b0, 10'd170, 10'd304, 8'd0);
    send_point(1'b0, 10'd172, 10'd304, 8'd0);     // gap too short stops the scan
    send_point(1'b0, 10'd1023, 10'd1023, 8'd255);
    send_point(1'b0, 10'd1023, 10'd0, 8'd255);
    send_point(1'b1, 10'd1023, 10'd1023, 8'd255);
    send_point(1'b0, 10'd512, 10'd512, 8'd0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(logic [10:0] height, logic [5:0] offset, logic [7:0] thr,
                               logic [9:0] gap_hi, logic [9:0] gap_lo);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_SAMPLE_OFFSET, 11'(offset));
    write_reg(REG_EDGE_THRESHOLD, 11'(thr));
    write_reg(REG_MAX_GAP, 11'(gap_hi));
    write_reg(REG_MIN_GAP, 11'(gap_lo));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, drain all candidates, then let a full scan time pass.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_directed();
    hold_req = 1'b1;
    send_bump_train();
    send_traffic(30);
    settle();
    load_settings(11'd1024, 6'd63, 8'd0, 10'd1023, 10'd0);
    send_traffic(30);
    settle();
    send_idle = 66;
    recv_idle = 37;
    load_settings(11'd1, 6'd0, 8'd255, 10'd0, 10'd1023);
    send_traffic(30);
    settle();
    load_settings(11'd480, 6'd10, 8'd8, 10'd45, 10'd15);
    send_traffic(30);
    settle();
    send_idle = 0;
    recv_idle = 0;
    load_settings(11'd0, 6'd31, 8'd20, 10'd60, 10'd10);
    send_traffic(30);
    settle();
    load_settings(11'd2047, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 40)),
                  10'($urandom_range(20, 300)), 10'($urandom_range(0, 30)));
    send_traffic(30);
    settle();
    if (mismatches == 0)
      $display("edge_pair_post_matcher test passed");
    else
      $display("edge_pair_post_matcher test failed");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("edge_pair_post_matcher test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/epm_pkg.sv
hdl/epm_ram.sv
hdl/epm_track.sv
hdl/epm_scan.sv
hdl/edge_pair_post_matcher.sv
bench/post_candidate_checker.sv
bench/tb.sv
